/* design/t1sp_pkg.sv */
`timescale 1ns / 1ps

package t1sp_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_PANEL_SHAPE = 2'd0;
    localparam logic [1:0] CFG_H_OVS_LOG2  = 2'd1;
    localparam logic [1:0] CFG_V_OVS_LOG2  = 2'd2;

    // Panel shape codes
    localparam logic [1:0] SHAPE_2X1 = 2'd0;
    localparam logic [1:0] SHAPE_2X2 = 2'd1;
    localparam logic [1:0] SHAPE_4X1 = 2'd2;

    localparam int AMP_W       = 14;
    localparam int TAB_W       = 16;
    localparam int MAG_W       = 29;
    localparam int QUEUE_DEPTH = 2;

    // Normalized configuration: shape is 2x1, 2x2 or 4x1, log2 factors saturated
    typedef struct packed {
        logic [1:0] shape;
        logic [1:0] lo1;
        logic [1:0] lo2;
    } t1sp_cfg_t;

    // One classified indicator as the front hands it to the back
    typedef struct packed {
        logic             invalid;
        logic [3:0]       i11;
        logic [3:0]       i12;
        logic [1:0]       phi;
        logic [3:0]       layers;
        logic [3:0]       k1;
        logic [2:0]       k2;
        logic [AMP_W-1:0] amp;
    } t1sp_desc_t;

    // Quarter wave of cos, Q1.14
    function automatic logic [14:0] cos_q(input logic [4:0] r);
        logic [14:0] v;
        case (r)
            5'd0:    v = 15'd16384;
            5'd1:    v = 15'd16305;
            5'd2:    v = 15'd16069;
            5'd3:    v = 15'd15679;
            5'd4:    v = 15'd15137;
            5'd5:    v = 15'd14449;
            5'd6:    v = 15'd13623;
            5'd7:    v = 15'd12665;
            5'd8:    v = 15'd11585;
            5'd9:    v = 15'd10394;
            5'd10:   v = 15'd9102;
            5'd11:   v = 15'd7723;
            5'd12:   v = 15'd6270;
            5'd13:   v = 15'd4756;
            5'd14:   v = 15'd3196;
            5'd15:   v = 15'd1606;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [TAB_W-1:0] cos64(input logic [5:0] k);
        logic signed [TAB_W-1:0] a;
        logic signed [TAB_W-1:0] b;
        logic signed [TAB_W-1:0] v;
        a = signed'({1'b0, cos_q({1'b0, k[3:0]})});
        b = signed'({1'b0, cos_q(5'd16 - {1'b0, k[3:0]})});
        case (k[5:4])
            2'd0:    v = a;
            2'd1:    v = -b;
            2'd2:    v = -a;
            default: v = b;
        endcase
        return v;
    endfunction

    function automatic logic signed [TAB_W-1:0] sin64(input logic [5:0] k);
        logic signed [TAB_W-1:0] a;
        logic signed [TAB_W-1:0] b;
        logic signed [TAB_W-1:0] v;
        a = signed'({1'b0, cos_q({1'b0, k[3:0]})});
        b = signed'({1'b0, cos_q(5'd16 - {1'b0, k[3:0]})});
        case (k[5:4])
            2'd0:    v = b;
            2'd1:    v = a;
            2'd2:    v = -b;
            default: v = -a;
        endcase
        return v;
    endfunction

    // round(2^14 / sqrt(layers * ports))
    function automatic logic [AMP_W-1:0] amp_lookup(input logic ports8, input logic [3:0] layers);
        logic [AMP_W-1:0] v;
        case ({ports8, layers})
            5'h01:   v = 14'd8192;
            5'h02:   v = 14'd5793;
            5'h03:   v = 14'd4730;
            5'h04:   v = 14'd4096;
            5'h11:   v = 14'd5793;
            5'h12:   v = 14'd4096;
            5'h13:   v = 14'd3344;
            5'h14:   v = 14'd2896;
            5'h15:   v = 14'd2591;
            5'h16:   v = 14'd2365;
            5'h17:   v = 14'd2189;
            5'h18:   v = 14'd2048;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    // 5 to 8 layers: horizontal offset in units of O1, two-row grid
    function automatic logic [1:0] hi_h2d(input logic [1:0] r, input logic [2:0] lay);
        logic [15:0] row;
        case (r)
            2'd0:    row = {2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0};
            2'd1:    row = {2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0};
            2'd2:    row = {2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0};
            default: row = {2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0};
        endcase
        return row[{lay, 1'b0} +: 2];
    endfunction

    // 5 to 8 layers: horizontal offset in units of O1, one-row grid
    function automatic logic [1:0] hi_h1d(input logic [1:0] r, input logic [2:0] lay);
        logic [15:0] row;
        case (r)
            2'd0:    row = {2'd0, 2'd0, 2'd0, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0};
            2'd1:    row = {2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0};
            2'd2:    row = {2'd0, 2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0};
            default: row = {2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0};
        endcase
        return row[{lay, 1'b0} +: 2];
    endfunction

    // 5 to 8 layers: vertical offset in units of O2
    function automatic logic hi_v(input logic [1:0] r, input logic [2:0] lay);
        logic [7:0] row;
        case (r)
            2'd0:    row = 8'b0001_0000;
            2'd1:    row = 8'b0011_0000;
            2'd2:    row = 8'b0111_1000;
            default: row = 8'b1111_0000;
        endcase
        return row[lay];
    endfunction

    // 5 to 8 layers: polarization code 0=phi, 1=-phi, 2=+1, 3=-1
    function automatic logic [1:0] hi_pol(input logic [1:0] r, input logic [2:0] lay);
        logic [15:0] row;
        case (r)
            2'd0:    row = {2'd0, 2'd0, 2'd0, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0};
            2'd1:    row = {2'd0, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0};
            2'd2:    row = {2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd0};
            default: row = {2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0};
        endcase
        return row[{lay, 1'b0} +: 2];
    endfunction

endpackage

/* design/t1sp_queue.sv */
`timescale 1ns / 1ps

module t1sp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  t1sp_pkg::t1sp_desc_t wdata,
    input  logic                pop,
    output t1sp_pkg::t1sp_desc_t rdata,
    output logic                full,
    output logic                not_empty
);
    import t1sp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t1sp_desc_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign rdata     = mem_reg[rd_ptr_reg];
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* design/t1sp_front.sv */
`timescale 1ns / 1ps

module t1sp_front #(
    parameter int MAX_LAYERS = 8,
    parameter int MAX_PORTS  = 8
) (
    input  t1sp_pkg::t1sp_cfg_t  cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [3:0]           s_beam_h,
    input  logic [3:0]           s_beam_v,
    input  logic [1:0]           s_beam_offset_sel,
    input  logic [1:0]           s_cophase,
    input  logic [3:0]           s_layers,
    input  logic                 q_full,
    output logic                 push,
    output t1sp_pkg::t1sp_desc_t desc
);
    import t1sp_pkg::*;

    logic       n2_2;
    logic       n1_4;
    logic       ports8;
    logic [3:0] ports;
    logic [3:0] o1;
    logic [2:0] o2;
    logic [3:0] k1;
    logic [2:0] k2;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    assign n2_2   = (cfg.shape == SHAPE_2X2);
    assign n1_4   = (cfg.shape == SHAPE_4X1);
    assign ports8 = n2_2 || n1_4;
    assign ports  = ports8 ? 4'd8 : 4'd4;
    assign o1     = 4'd1 << cfg.lo1;
    assign o2     = 3'd1 << cfg.lo2;

    // beam offsets k1/k2 for 2 to 4 layers
    always_comb begin
        k1 = '0;
        k2 = '0;
        if (s_layers == 4'd2) begin
            if (n2_2) begin
                case (s_beam_offset_sel)
                    2'd1:    k1 = o1;
                    2'd2:    k2 = o2;
                    2'd3: begin
                        k1 = o1;
                        k2 = o2;
                    end
                    default: ;
                endcase
            end else if (!n1_4) begin
                if (s_beam_offset_sel == 2'd1) k1 = o1;
            end else begin
                k1 = 4'({2'b00, s_beam_offset_sel} << cfg.lo1);
            end
        end else if (s_layers == 4'd3 || s_layers == 4'd4) begin
            if (n2_2) begin
                case (s_beam_offset_sel)
                    2'd0:    k1 = o1;
                    2'd1:    k2 = o2;
                    2'd2: begin
                        k1 = o1;
                        k2 = o2;
                    end
                    default: ;
                endcase
            end else if (!n1_4) begin
                k1 = o1;
            end else if (s_beam_offset_sel != 2'd3) begin
                k1 = 4'(({2'b00, s_beam_offset_sel} + 4'd1) << cfg.lo1);
            end
        end
    end

    // classified word for the queue
    always_comb begin
        desc.invalid = (s_layers == 4'd0) || (s_layers > ports) ||
                       (int'(s_layers) > MAX_LAYERS) || (int'(ports) > MAX_PORTS);
        desc.i11     = s_beam_h;
        desc.i12     = n2_2 ? s_beam_v : 4'd0;
        desc.phi     = s_cophase;
        desc.layers  = s_layers;
        desc.k1      = k1;
        desc.k2      = k2;
        desc.amp     = amp_lookup(ports8, s_layers);
    end

endmodule

/* design/t1sp_back.sv */
`timescale 1ns / 1ps

module t1sp_back #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  t1sp_pkg::t1sp_cfg_t           cfg,
    input  logic                          head_valid,
    input  t1sp_pkg::t1sp_desc_t          head,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_layer_idx,
    output logic [2:0]                    m_port_idx,
    output logic signed [WEIGHT_BITS-1:0] m_weight_re,
    output logic signed [WEIGHT_BITS-1:0] m_weight_im,
    output logic                          m_last,
    output logic                          m_status
);
    import t1sp_pkg::*;

    localparam int SH    = 30 - WEIGHT_BITS;
    localparam int RND_W = MAG_W + 1;

    // sequencer
    logic [2:0] lay_reg;
    logic [2:0] port_reg;

    // stage 1: table values
    logic                    s1_valid_reg;
    logic [2:0]              s1_lay_reg;
    logic [2:0]              s1_port_reg;
    logic                    s1_last_reg;
    logic                    s1_status_reg;
    logic signed [TAB_W-1:0] s1_re_reg;
    logic signed [TAB_W-1:0] s1_im_reg;
    logic [AMP_W-1:0]        s1_amp_reg;

    // stage 2: products
    logic             s2_valid_reg;
    logic [2:0]       s2_lay_reg;
    logic [2:0]       s2_port_reg;
    logic             s2_last_reg;
    logic             s2_status_reg;
    logic [MAG_W-1:0] s2_mag_re_reg;
    logic [MAG_W-1:0] s2_mag_im_reg;
    logic             s2_neg_re_reg;
    logic             s2_neg_im_reg;

    // output register
    logic                          m_valid_reg;
    logic [2:0]                    m_layer_idx_reg;
    logic [2:0]                    m_port_idx_reg;
    logic signed [WEIGHT_BITS-1:0] m_weight_re_reg;
    logic signed [WEIGHT_BITS-1:0] m_weight_im_reg;
    logic                          m_last_reg;
    logic                          m_status_reg;

    logic       adv;
    logic       issue;
    logic       item_last;
    logic       last_port;
    logic       n2_2;
    logic       n1_4;
    logic [2:0] ports_m1;
    logic       upper;
    logic [4:0] l;
    logic [4:0] m;
    logic [1:0] polq;
    logic [1:0] r;
    logic [1:0] hh;
    logic [1:0] code;
    logic [1:0] ih;
    logic       iv;
    logic [2:0] dh;
    logic [2:0] dv;
    logic [6:0] prod_h;
    logic [5:0] prod_v;
    logic [5:0] th;
    logic [5:0] tv;
    logic [5:0] k;

    logic [TAB_W-2:0]       abs_re;
    logic [TAB_W-2:0]       abs_im;
    logic [RND_W-1:0]       rnd_re;
    logic [RND_W-1:0]       rnd_im;
    logic [WEIGHT_BITS-1:0] part_re;
    logic [WEIGHT_BITS-1:0] part_im;

    // whole pipeline moves when the output register is free
    assign adv       = !m_valid_reg || m_ready;
    assign n2_2      = (cfg.shape == SHAPE_2X2);
    assign n1_4      = (cfg.shape == SHAPE_4X1);
    assign ports_m1  = (n2_2 || n1_4) ? 3'd7 : 3'd3;
    assign upper     = (n2_2 || n1_4) ? port_reg[2] : port_reg[1];
    assign last_port = (port_reg == ports_m1);
    assign item_last = head.invalid ||
                       (last_port && (lay_reg == 3'(head.layers - 4'd1)));
    assign issue     = head_valid && adv;
    assign pop       = issue && item_last;

    // per-layer beam offsets and polarization phase
    always_comb begin
        l    = {1'b0, head.i11};
        m    = {1'b0, head.i12};
        polq = head.phi;
        r    = 2'(head.layers - 4'd5);
        hh   = n2_2 ? hi_h2d(r, lay_reg) : hi_h1d(r, lay_reg);
        code = hi_pol(r, lay_reg);
        if (head.layers == 4'd2) begin
            if (lay_reg == 3'd1) begin
                l    = l + {1'b0, head.k1};
                m    = m + {2'b00, head.k2};
                polq = polq + 2'd2;
            end
        end else if (head.layers == 4'd3 || head.layers == 4'd4) begin
            if (lay_reg[0]) begin
                l = l + {1'b0, head.k1};
                m = m + {2'b00, head.k2};
            end
            if (lay_reg[2:1] != 2'b00) polq = polq + 2'd2;
        end else if (head.layers >= 4'd5) begin
            l    = l + 5'({3'b000, hh} << cfg.lo1);
            m    = m + 5'({4'b0000, hi_v(r, lay_reg)} << cfg.lo2);
            polq = (code[1] ? 2'd0 : head.phi) + (code[0] ? 2'd2 : 2'd0);
        end
        if (!n2_2) m = '0;
    end

    // element position and phase step
    always_comb begin
        if (n2_2) begin
            ih = {1'b0, port_reg[1]};
            iv = port_reg[0];
        end else if (n1_4) begin
            ih = port_reg[1:0];
            iv = 1'b0;
        end else begin
            ih = {1'b0, port_reg[0]};
            iv = 1'b0;
        end
        dh     = {1'b0, cfg.lo1} + (n1_4 ? 3'd2 : 3'd1);
        dv     = {1'b0, cfg.lo2} + 3'd1;
        prod_h = {2'b00, l} * {5'b00000, ih};
        prod_v = {1'b0, m} & {6{iv}};
        th     = prod_h[5:0] << (3'd6 - dh);
        tv     = prod_v << (3'd6 - dv);
        k      = th + tv + (upper ? {polq, 4'b0000} : 6'd0);
    end

    // sequencer over layers and ports
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lay_reg  <= '0;
            port_reg <= '0;
        end else if (issue) begin
            if (item_last) begin
                lay_reg  <= '0;
                port_reg <= '0;
            end else if (last_port) begin
                lay_reg  <= lay_reg + 3'd1;
                port_reg <= '0;
            end else begin
                port_reg <= port_reg + 3'd1;
            end
        end
    end

    // pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= head_valid;
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg  <= s2_valid_reg;
        end
    end

    assign abs_re = (TAB_W - 1)'(s1_re_reg[TAB_W-1] ? -s1_re_reg : s1_re_reg);
    assign abs_im = (TAB_W - 1)'(s1_im_reg[TAB_W-1] ? -s1_im_reg : s1_im_reg);

    // rounding half away from zero, then sign
    assign rnd_re  = (RND_W'(s2_mag_re_reg) + (RND_W'(1) << (SH - 1))) >> SH;
    assign rnd_im  = (RND_W'(s2_mag_im_reg) + (RND_W'(1) << (SH - 1))) >> SH;
    assign part_re = rnd_re[WEIGHT_BITS-1:0];
    assign part_im = rnd_im[WEIGHT_BITS-1:0];

    // payload stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_lay_reg    <= head.invalid ? 3'd0 : lay_reg;
            s1_port_reg   <= head.invalid ? 3'd0 : port_reg;
            s1_last_reg   <= item_last;
            s1_status_reg <= head.invalid;
            s1_re_reg     <= head.invalid ? '0 : cos64(k);
            s1_im_reg     <= head.invalid ? '0 : sin64(k);
            s1_amp_reg    <= head.invalid ? '0 : head.amp;

            s2_lay_reg    <= s1_lay_reg;
            s2_port_reg   <= s1_port_reg;
            s2_last_reg   <= s1_last_reg;
            s2_status_reg <= s1_status_reg;
            s2_mag_re_reg <= abs_re * s1_amp_reg;
            s2_mag_im_reg <= abs_im * s1_amp_reg;
            s2_neg_re_reg <= s1_re_reg[TAB_W-1];
            s2_neg_im_reg <= s1_im_reg[TAB_W-1];

            m_layer_idx_reg <= s2_lay_reg;
            m_port_idx_reg  <= s2_port_reg;
            m_last_reg      <= s2_last_reg;
            m_status_reg    <= s2_status_reg;
            m_weight_re_reg <= signed'(s2_neg_re_reg ? -part_re : part_re);
            m_weight_im_reg <= signed'(s2_neg_im_reg ? -part_im : part_im);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_layer_idx = m_layer_idx_reg;
    assign m_port_idx  = m_port_idx_reg;
    assign m_weight_re = m_weight_re_reg;
    assign m_weight_im = m_weight_im_reg;
    assign m_last      = m_last_reg;
    assign m_status    = m_status_reg;

endmodule

/* design/type1_single_panel_precoder_weights.sv */
`timescale 1ns / 1ps

// Type I single-panel (mode 1) precoder weight generator.
// Input channel s_*: one precoding matrix indicator per word (beam_h, beam_v,
// beam_offset_sel, cophase, layers), valid/ready.
// Output channel m_*: one weight per word, layer-major and port-minor, with
// m_last on the final word of an indicator. A bad layer count gives a single
// word with status 1, zero weight and last set.
// Configuration: cfg_we/cfg_index/cfg_wdata write panel_shape (0),
// h_oversample_log2 (1) and v_oversample_log2 (2); change them only when idle.
// Output size: layers*ports weights per indicator (4 to 64), one word for a
// rejected one; the back-end sequencer issues one weight per cycle while the
// receiver is ready. Each indicator passes the queue, then issue with table
// lookup, multiply, and round into the output register.
// A two-entry queue lets the front take new indicators while the back works.
// If the receiver stalls, the whole back pipeline holds; the front keeps
// accepting until the queue is full.
// Reset: queue and pipeline empty, registers back to 2x1 panel, O1=4, O2=1.
module type1_single_panel_precoder_weights #(
    parameter int MAX_LAYERS  = 8,
    parameter int MAX_PORTS   = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [1:0]                    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [3:0]                    s_beam_h,
    input  logic [3:0]                    s_beam_v,
    input  logic [1:0]                    s_beam_offset_sel,
    input  logic [1:0]                    s_cophase,
    input  logic [3:0]                    s_layers,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_layer_idx,
    output logic [2:0]                    m_port_idx,
    output logic signed [WEIGHT_BITS-1:0] m_weight_re,
    output logic signed [WEIGHT_BITS-1:0] m_weight_im,
    output logic                          m_last,
    output logic                          m_status
);
    import t1sp_pkg::*;

    logic [1:0] panel_shape_reg;
    logic [1:0] h_ovs_reg;
    logic [1:0] v_ovs_reg;

    t1sp_cfg_t  cfg;
    t1sp_desc_t push_desc;
    t1sp_desc_t head_desc;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_not_empty;
    logic       ports8;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            panel_shape_reg <= SHAPE_2X1;
            h_ovs_reg       <= 2'd2;
            v_ovs_reg       <= 2'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PANEL_SHAPE: panel_shape_reg <= cfg_wdata;
                CFG_H_OVS_LOG2:  h_ovs_reg       <= cfg_wdata;
                CFG_V_OVS_LOG2:  v_ovs_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // unused shape acts as 2x1, oversampling code 3 saturates to factor 4
    assign cfg.shape = (panel_shape_reg == SHAPE_2X2 || panel_shape_reg == SHAPE_4X1) ?
                       panel_shape_reg : SHAPE_2X1;
    assign cfg.lo1   = (h_ovs_reg == 2'd3) ? 2'd2 : h_ovs_reg;
    assign cfg.lo2   = (v_ovs_reg == 2'd3) ? 2'd2 : v_ovs_reg;
    assign ports8    = (cfg.shape == SHAPE_2X2) || (cfg.shape == SHAPE_4X1);

    t1sp_front #(
        .MAX_LAYERS (MAX_LAYERS),
        .MAX_PORTS  (MAX_PORTS)
    ) u_front (
        .cfg               (cfg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_beam_h          (s_beam_h),
        .s_beam_v          (s_beam_v),
        .s_beam_offset_sel (s_beam_offset_sel),
        .s_cophase         (s_cophase),
        .s_layers          (s_layers),
        .q_full            (q_full),
        .push              (push),
        .desc              (push_desc)
    );

    t1sp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wdata     (push_desc),
        .pop       (pop),
        .rdata     (head_desc),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    t1sp_back #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .head_valid  (q_not_empty),
        .head        (head_desc),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_layer_idx (m_layer_idx),
        .m_port_idx  (m_port_idx),
        .m_weight_re (m_weight_re),
        .m_weight_im (m_weight_im),
        .m_last      (m_last),
        .m_status    (m_status)
    );

    // an accepted indicator is in the queue on the next cycle
    a_accept_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> q_not_empty)
        else $error("accepted indicator missing from queue");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    // an error word is a lone, last, zero word
    a_error_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_last && m_weight_re == '0 && m_weight_im == '0 &&
                                   m_layer_idx == 3'd0 && m_port_idx == 3'd0))
        else $error("malformed error word");

    // a four-port panel never emits an upper port index
    a_port_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_status && !ports8) |-> !m_port_idx[2])
        else $error("port index beyond port count");

endmodule
